/* hw/rtl/jti_pkg.sv */
// shared types and constants of the joint trajectory interpolator
package jti_pkg;

  localparam int ALPHA_BITS = 24;
  localparam int DIV_STEPS = ALPHA_BITS + 1;
  localparam logic [ALPHA_BITS:0] ALPHA_ONE = {1'b1, {ALPHA_BITS{1'b0}}};
  localparam logic [30:0] TOLERANCE_RESET = 31'd6554;
  localparam logic [31:0] TIMEOUT_RESET = 32'd3000000;
  localparam logic CFG_TOLERANCE = 1'b0;
  localparam logic CFG_TIMEOUT = 1'b1;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_START  = 2'd1,
    OP_TICK   = 2'd2,
    OP_CANCEL = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WRITE,
    S_ST_READ,
    S_ST_CHECK,
    S_TK_READ,
    S_TK_CHECK,
    S_DIV_INIT,
    S_DIV,
    S_LMUL,
    S_LADD,
    S_HOLD,
    S_DONE
  } state_t;

  // one table point
  typedef struct packed {
    logic [2:0]  present;
    logic [31:0] time_us;
    logic [31:0] position;
    logic [31:0] velocity;
    logic [31:0] acceleration;
  } point_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic write_pt;
    logic cancel;
    logic rd_first;
    logic rd_next;
    logic start_check;
    logic set_point0;
    logic found_cur;
    logic div_init;
    logic div_step;
    logic mul;
    logic add;
    logic hold_last;
    logic hold_check;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic running;
    logic found;
    logic at_first;
    logic at_last;
    logic span_pos;
    logic div_last;
    logic lerp_last;
  } stat_t;

endpackage

/* hw/rtl/joint_trajectory_interpolator_top.sv */
// top level of the joint trajectory interpolator
//
// Command channel: an item (load, start, tick or cancel) is taken when start
// is high and busy is low. Its single result appears for one cycle with done
// high; the receiver cannot stall, so the result must be taken then.
// Configuration: cfg_write with cfg_index 0 (final tolerance) or 1 (final
// timeout) writes cfg_data at once; write only while busy is low.
// A running tick scans the point table through one memory read port with
// registered data, reading and then checking each point in turn. An
// interpolating tick then runs the bit-serial alpha divider and three
// multiply and add passes on the shared multiplier; holding past the last
// point adds a hold check state.
// One item is in flight at a time; the next is taken after done.
// Reset clears the trajectory state, targets and configuration; the point
// table is not cleared and must be loaded before use.
module joint_trajectory_interpolator_top import jti_pkg::*; #(
  parameter int MAX_POINTS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  output logic        done,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic [1:0]  operation,
  input  logic [5:0]  point_index,
  input  logic [31:0] point_time_us,
  input  logic [31:0] point_position,
  input  logic [31:0] point_velocity,
  input  logic [31:0] point_acceleration,
  input  logic [2:0]  present_mask,
  input  logic [6:0]  point_count,
  input  logic [31:0] now_us,
  input  logic [31:0] measured_position,
  output logic [31:0] setpoint_position,
  output logic [31:0] setpoint_velocity,
  output logic [31:0] setpoint_acceleration,
  output logic        trajectory_active,
  output logic [5:0]  segment_index,
  output logic        status
);

  cmd_t  cmd;
  stat_t stat;

  // sequencer
  jti_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (operation),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .done      (done)
  );

  // table, divider and interpolator
  jti_dp #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk                   (clk),
    .rst                   (rst),
    .cmd                   (cmd),
    .stat                  (stat),
    .cfg_write             (cfg_write),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .point_index           (point_index),
    .point_time_us         (point_time_us),
    .point_position        (point_position),
    .point_velocity        (point_velocity),
    .point_acceleration    (point_acceleration),
    .present_mask          (present_mask),
    .point_count           (point_count),
    .now_us                (now_us),
    .measured_position     (measured_position),
    .setpoint_position     (setpoint_position),
    .setpoint_velocity     (setpoint_velocity),
    .setpoint_acceleration (setpoint_acceleration),
    .trajectory_active     (trajectory_active),
    .segment_index         (segment_index),
    .status                (status)
  );

endmodule

/* hw/rtl/jti_ctrl.sv */
// controller state machine of the joint trajectory interpolator
module jti_ctrl import jti_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [1:0] operation,
  input  stat_t      stat,
  output cmd_t       cmd,
  output logic       busy,
  output logic       done
);

  state_t state, state_next;
  logic   accept;
  op_t    op;

  assign accept = start && (state == S_IDLE);
  assign op = op_t'(operation);
  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (op)
            OP_LOAD:   state_next = S_WRITE;
            OP_START:  state_next = S_ST_READ;
            OP_TICK:   state_next = stat.running ? S_TK_READ : S_DONE;
            OP_CANCEL: state_next = S_DONE;
            default:   state_next = S_DONE;
          endcase
        end
      end
      S_WRITE:    state_next = S_DONE;
      S_ST_READ:  state_next = S_ST_CHECK;
      S_ST_CHECK: state_next = S_DONE;
      S_TK_READ:  state_next = S_TK_CHECK;
      S_TK_CHECK: begin
        if (stat.found) begin
          state_next = stat.at_first ? S_DONE : S_DIV_INIT;
        end else if (stat.at_last) begin
          state_next = S_HOLD;
        end else begin
          state_next = S_TK_READ;
        end
      end
      S_DIV_INIT: state_next = stat.span_pos ? S_DIV : S_LMUL;
      S_DIV:      state_next = stat.div_last ? S_LMUL : S_DIV;
      S_LMUL:     state_next = S_LADD;
      S_LADD:     state_next = stat.lerp_last ? S_DONE : S_LMUL;
      S_HOLD:     state_next = S_DONE;
      S_DONE:     state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.capture = 1'b1;
          cmd.rd_first = (op == OP_START) || ((op == OP_TICK) && stat.running);
          cmd.cancel = (op == OP_CANCEL);
        end
      end
      S_WRITE:    cmd.write_pt = 1'b1;
      S_ST_CHECK: cmd.start_check = 1'b1;
      S_TK_CHECK: begin
        if (stat.found) begin
          cmd.set_point0 = stat.at_first;
          cmd.found_cur = !stat.at_first;
        end else if (stat.at_last) begin
          cmd.hold_last = 1'b1;
        end else begin
          cmd.rd_next = 1'b1;
        end
      end
      S_DIV_INIT: cmd.div_init = 1'b1;
      S_DIV:      cmd.div_step = 1'b1;
      S_LMUL:     cmd.mul = 1'b1;
      S_LADD:     cmd.add = 1'b1;
      S_HOLD:     cmd.hold_check = 1'b1;
      default:    cmd = '0;
    endcase
  end

endmodule

/* hw/rtl/jti_dp.sv */
// datapath of the joint trajectory interpolator: point table, divider, interpolator
module jti_dp import jti_pkg::*; #(
  parameter int MAX_POINTS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output stat_t       stat,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic [5:0]  point_index,
  input  logic [31:0] point_time_us,
  input  logic [31:0] point_position,
  input  logic [31:0] point_velocity,
  input  logic [31:0] point_acceleration,
  input  logic [2:0]  present_mask,
  input  logic [6:0]  point_count,
  input  logic [31:0] now_us,
  input  logic [31:0] measured_position,
  output logic [31:0] setpoint_position,
  output logic [31:0] setpoint_velocity,
  output logic [31:0] setpoint_acceleration,
  output logic        trajectory_active,
  output logic [5:0]  segment_index,
  output logic        status
);

  localparam int IW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);

  // point table
  point_t mem [MAX_POINTS];
  point_t rd_data;
  logic [IW-1:0] rd_addr;

  // latched item
  logic [5:0]  idx_q;
  point_t      pt_q;
  logic [6:0]  cnt_q;
  logic [31:0] now_q;
  logic [31:0] meas_q;

  // configuration
  logic [30:0] tolerance;
  logic [31:0] timeout;

  // trajectory state
  logic [CW-1:0] active_count;
  logic [31:0]   start_time;
  logic          running;
  logic [31:0]   held_pos, held_vel, held_acc;
  logic          wait_started;
  logic [31:0]   wait_time;
  logic [5:0]    seg;
  logic          status_q;

  // interpolation
  point_t             prev, cur;
  logic [31:0]        rem;
  logic [ALPHA_BITS:0] alpha;
  logic [4:0]         div_cnt;
  logic [1:0]         lane;
  logic signed [58:0] prod;

  logic [31:0]   elapsed;
  logic [CW-1:0] cnt_sat;
  logic [31:0]   den, ediff;
  logic [32:0]   trial;
  logic          div_bit;
  logic [31:0]   a_sel, b_sel;
  logic signed [32:0] diff;
  logic signed [34:0] shifted;
  logic [32:0]   lerp_sum;
  logic [2:0]    both;
  logic signed [32:0] err;
  logic [32:0]   err_abs;

  assign elapsed = now_q - start_time;
  assign cnt_sat = (32'(cnt_q) > MAX_POINTS) ? CW'(MAX_POINTS) : CW'(cnt_q);
  assign den = cur.time_us - prev.time_us;
  assign ediff = elapsed - prev.time_us;
  assign div_bit = (div_cnt == 5'd0) ? ediff[0] : 1'b0;
  assign trial = {rem, div_bit};

  // lane select for the shared multiplier
  always_comb begin
    case (lane)
      2'd0:    begin a_sel = prev.position;     b_sel = cur.position;     end
      2'd1:    begin a_sel = prev.velocity;     b_sel = cur.velocity;     end
      default: begin a_sel = prev.acceleration; b_sel = cur.acceleration; end
    endcase
  end

  assign diff = $signed({b_sel[31], b_sel}) - $signed({a_sel[31], a_sel});
  assign shifted = 35'(prod >>> ALPHA_BITS);
  assign lerp_sum = 33'($signed({a_sel[31], a_sel}) + shifted[32:0]);
  assign both = prev.present & cur.present;
  assign err = $signed({held_pos[31], held_pos}) - $signed({meas_q[31], meas_q});
  assign err_abs = err[32] ? 33'(-err) : 33'(err);

  // status to controller
  assign stat.running = running;
  assign stat.found = (elapsed <= rd_data.time_us);
  assign stat.at_first = (rd_addr == '0);
  assign stat.at_last = (CW'({1'b0, rd_addr}) + CW'(1) == active_count);
  assign stat.span_pos = (cur.time_us > prev.time_us);
  assign stat.div_last = (div_cnt == 5'(DIV_STEPS - 1));
  assign stat.lerp_last = (lane == 2'd2);

  // table write and registered read
  always_ff @(posedge clk) begin
    if (cmd.write_pt && (32'(idx_q) < MAX_POINTS)) begin
      mem[IW'(idx_q)] <= pt_q;
    end
    rd_data <= mem[rd_addr];
  end

  // item capture and scan address
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      idx_q <= point_index;
      pt_q <= '{present_mask, point_time_us, point_position, point_velocity,
                point_acceleration};
      cnt_q <= point_count;
      now_q <= now_us;
      meas_q <= measured_position;
    end
    if (cmd.rd_first) begin
      rd_addr <= '0;
    end else if (cmd.rd_next) begin
      rd_addr <= rd_addr + IW'(1);
      prev <= rd_data;
    end
    if (cmd.found_cur) begin
      cur <= rd_data;
    end
  end

  // divider for alpha, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem <= ediff >> 1;
      div_cnt <= '0;
      alpha <= stat.span_pos ? '0 : ALPHA_ONE;
      lane <= '0;
    end else if (cmd.div_step) begin
      if (trial >= {1'b0, den}) begin
        rem <= 32'(trial - {1'b0, den});
        alpha <= {alpha[ALPHA_BITS-1:0], 1'b1};
      end else begin
        rem <= trial[31:0];
        alpha <= {alpha[ALPHA_BITS-1:0], 1'b0};
      end
      div_cnt <= div_cnt + 5'd1;
    end else if (cmd.add) begin
      lane <= lane + 2'd1;
    end
    if (cmd.mul) begin
      prod <= 59'(diff * $signed({1'b0, alpha}));
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= TOLERANCE_RESET;
      timeout <= TIMEOUT_RESET;
    end else if (cfg_write) begin
      if (cfg_index == CFG_TOLERANCE) begin
        tolerance <= cfg_data[30:0];
      end else if (cfg_index == CFG_TIMEOUT) begin
        timeout <= cfg_data;
      end
    end
  end

  // trajectory state and held targets
  always_ff @(posedge clk) begin
    if (rst) begin
      active_count <= '0;
      start_time <= '0;
      running <= 1'b0;
      held_pos <= '0;
      held_vel <= '0;
      held_acc <= '0;
      wait_started <= 1'b0;
      wait_time <= '0;
      seg <= '0;
      status_q <= 1'b0;
    end else begin
      if (cmd.capture) begin
        status_q <= 1'b0;
      end
      if (cmd.cancel) begin
        running <= 1'b0;
        wait_started <= 1'b0;
      end
      if (cmd.start_check) begin
        if ((cnt_sat == '0) || !rd_data.present[0]) begin
          status_q <= 1'b1;
        end else begin
          active_count <= cnt_sat;
          start_time <= now_q;
          running <= 1'b1;
          wait_started <= 1'b0;
        end
      end
      if (cmd.set_point0) begin
        seg <= '0;
        if (rd_data.present[0]) begin
          held_pos <= rd_data.position;
        end
        held_vel <= rd_data.present[1] ? rd_data.velocity : '0;
        held_acc <= rd_data.present[2] ? rd_data.acceleration : '0;
      end
      if (cmd.found_cur) begin
        seg <= 6'(rd_addr);
      end
      if (cmd.add) begin
        case (lane)
          2'd0: begin
            if (both[0]) begin
              held_pos <= lerp_sum[31:0];
            end
          end
          2'd1:    held_vel <= both[1] ? lerp_sum[31:0] : '0;
          default: held_acc <= both[2] ? lerp_sum[31:0] : '0;
        endcase
      end
      if (cmd.hold_last) begin
        seg <= 6'(rd_addr);
        if (rd_data.present[0]) begin
          held_pos <= rd_data.position;
        end
        held_vel <= '0;
        held_acc <= '0;
        if (!wait_started) begin
          wait_started <= 1'b1;
          wait_time <= now_q;
        end
      end
      if (cmd.hold_check) begin
        if ((err_abs < {2'b00, tolerance}) || ((now_q - wait_time) > timeout)) begin
          running <= 1'b0;
          wait_started <= 1'b0;
        end
      end
    end
  end

  assign setpoint_position = held_pos;
  assign setpoint_velocity = held_vel;
  assign setpoint_acceleration = held_acc;
  assign trajectory_active = running;
  assign segment_index = seg;
  assign status = status_q;

endmodule
